### design/kst_pkg.sv
// types and codes shared by the keyed slot table and its record store
// no dependencies
`default_nettype none

package kst_pkg;

  localparam logic [2:0] CMD_FIND      = 3'd0;
  localparam logic [2:0] CMD_FIND_TYPE = 3'd1;
  localparam logic [2:0] CMD_SPAWN     = 3'd2;
  localparam logic [2:0] CMD_DESPAWN   = 3'd3;
  localparam logic [2:0] CMD_DESTROY   = 3'd4;

  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_NOT_FOUND  = 3'd1;
  localparam logic [2:0] STAT_WRONG_TYPE = 3'd2;
  localparam logic [2:0] STAT_EXISTS     = 3'd3;
  localparam logic [2:0] STAT_FULL       = 3'd4;
  localparam logic [2:0] STAT_INVALID    = 3'd5;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] key_id;
    logic [7:0]  kind;
    logic        include_retired;
    logic [31:0] time_now;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  slot_index;
    logic [7:0]  record_kind;
    logic [31:0] born_time;
    logic [31:0] retired_time;
    logic        retired;
  } rsp_t;

  // one slot of the store; key zero marks a free slot
  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  kind;
    logic [31:0] born;
    logic [31:0] retired_time;
    logic        retired;
  } rec_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

### design/kst_store.sv
// record store: one write port, one read port with registered read data
// depends on kst_pkg for the record type
`default_nettype none

module kst_store #(
  parameter int AW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire kst_pkg::rec_t wdata,
  input  wire logic [AW-1:0] raddr,
  output kst_pkg::rec_t      rdata
);

  kst_pkg::rec_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/keyed_slot_table.sv
// keyed slot table: one transaction at a time; a lookup scans slots 1 upward, one per cycle,
// through the single read port of the record store and stops at the matching id.
// a rejected argument skips the scan; otherwise the scan runs until a hit or the last slot.
// a new request is taken while a result still waits for rsp_ready.
// reset: synchronous; a clearing pass then writes every slot, with req_ready low.
// depends on kst_pkg and kst_store
`default_nettype none

module keyed_slot_table #(
  parameter int SLOT_COUNT = 256,
  parameter int LIVE_LIMIT = 255
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire kst_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output kst_pkg::rsp_t      rsp
);

  localparam int AW = $clog2(SLOT_COUNT);
  localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);

  kst_pkg::state_t state, state_next;
  logic [AW-1:0]   cur;
  logic            bad;
  logic            hit;
  logic            free_found;
  logic [AW-1:0]   hit_slot;
  logic [AW-1:0]   free_slot;
  logic [AW-1:0]   live_count, live_count_next;
  kst_pkg::req_t   cur_req;
  kst_pkg::rec_t   hit_rec;
  kst_pkg::rsp_t   rsp_next;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  kst_pkg::rec_t   mem_wdata;
  logic [AW-1:0]   mem_raddr;
  kst_pkg::rec_t   rd_data;

  logic req_bad;
  logic key_hit;
  logic rsp_space;
  logic done;

  assign req_bad = (req.key_id == 32'd0) || (req.cmd > kst_pkg::CMD_DESTROY) ||
                   (req.cmd == kst_pkg::CMD_SPAWN && req.kind == 8'd0);
  assign key_hit   = (rd_data.key == cur_req.key_id);
  assign rsp_space = !rsp_valid || rsp_ready;
  assign req_ready = (state == kst_pkg::S_IDLE);
  assign done      = (state == kst_pkg::S_FINISH) && rsp_space;

  kst_store #(.AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      kst_pkg::S_CLEAR: begin
        if (cur == LAST) state_next = kst_pkg::S_IDLE;
      end
      kst_pkg::S_IDLE: begin
        if (req_valid) state_next = req_bad ? kst_pkg::S_FINISH : kst_pkg::S_SCAN;
      end
      kst_pkg::S_SCAN: begin
        if (key_hit || cur == LAST) state_next = kst_pkg::S_FINISH;
      end
      kst_pkg::S_FINISH: begin
        if (rsp_space) state_next = kst_pkg::S_IDLE;
      end
      default: state_next = kst_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    logic [2:0]    st;
    logic [AW-1:0] slot;
    kst_pkg::rec_t shown;
    logic          wr;
    kst_pkg::rec_t wrec;

    st    = kst_pkg::STAT_INVALID;
    slot  = hit_slot;
    shown = hit_rec;
    wr    = 1'b0;
    wrec  = '0;
    live_count_next = live_count;

    if (!bad) begin
      case (cur_req.cmd)
        kst_pkg::CMD_FIND, kst_pkg::CMD_FIND_TYPE: begin
          if (!hit || (hit_rec.retired && !cur_req.include_retired)) begin
            st = kst_pkg::STAT_NOT_FOUND;
          end else if (cur_req.cmd == kst_pkg::CMD_FIND_TYPE &&
                       hit_rec.kind != cur_req.kind) begin
            st = kst_pkg::STAT_WRONG_TYPE;
          end else begin
            st = kst_pkg::STAT_OK;
          end
        end
        kst_pkg::CMD_SPAWN: begin
          if (hit) begin
            st = kst_pkg::STAT_EXISTS;
          end else if (free_found && (32'(live_count) < 32'(LIVE_LIMIT))) begin
            st                = kst_pkg::STAT_OK;
            slot              = free_slot;
            wrec.key          = cur_req.key_id;
            wrec.kind         = cur_req.kind;
            wrec.born         = cur_req.time_now;
            wrec.retired_time = 32'd0;
            wrec.retired      = 1'b0;
            shown             = wrec;
            wr                = 1'b1;
            live_count_next   = live_count + AW'(1);
          end else begin
            st = kst_pkg::STAT_FULL;
          end
        end
        kst_pkg::CMD_DESPAWN: begin
          if (!hit || hit_rec.retired) begin
            st = kst_pkg::STAT_NOT_FOUND;
          end else begin
            st                = kst_pkg::STAT_OK;
            wrec              = hit_rec;
            wrec.retired_time = cur_req.time_now;
            wrec.retired      = 1'b1;
            shown             = wrec;
            wr                = 1'b1;
          end
        end
        kst_pkg::CMD_DESTROY: begin
          if (!hit) begin
            st = kst_pkg::STAT_NOT_FOUND;
          end else begin
            // report the record as it stood, then free the slot
            st = kst_pkg::STAT_OK;
            wr = 1'b1;
            if (live_count != '0) live_count_next = live_count - AW'(1);
          end
        end
        default: st = kst_pkg::STAT_INVALID;
      endcase
    end

    rsp_next        = '0;
    rsp_next.status = st;
    if (st == kst_pkg::STAT_OK) begin
      rsp_next.slot_index   = 8'(slot);
      rsp_next.record_kind  = shown.kind;
      rsp_next.born_time    = shown.born;
      rsp_next.retired_time = shown.retired_time;
      rsp_next.retired      = shown.retired;
    end

    if (!done) live_count_next = live_count;

    // store port control
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = '0;
    case (state)
      kst_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cur;
      end
      kst_pkg::S_FINISH: begin
        mem_we    = done && wr;
        mem_waddr = slot;
        mem_wdata = wrec;
      end
      default: mem_we = 1'b0;
    endcase

    case (state)
      kst_pkg::S_IDLE: mem_raddr = AW'(1);
      kst_pkg::S_SCAN: mem_raddr = (cur == LAST) ? cur : cur + AW'(1);
      default:         mem_raddr = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= kst_pkg::S_CLEAR;
      cur        <= '0;
      bad        <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      live_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      live_count <= live_count_next;
      case (state)
        kst_pkg::S_CLEAR: begin
          cur <= cur + AW'(1);
        end
        kst_pkg::S_IDLE: begin
          if (req_valid) begin
            bad        <= req_bad;
            cur        <= AW'(1);
            hit        <= 1'b0;
            free_found <= 1'b0;
          end
        end
        kst_pkg::S_SCAN: begin
          // rd_data holds the slot at cur
          if (key_hit) begin
            hit <= 1'b1;
          end else begin
            if (rd_data.key == 32'd0 && !free_found) free_found <= 1'b1;
            if (cur != LAST) cur <= cur + AW'(1);
          end
        end
        default: cur <= cur;
      endcase
      if (done) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == kst_pkg::S_IDLE && req_valid) begin
      cur_req <= req;
    end
    if (state == kst_pkg::S_SCAN) begin
      if (key_hit) begin
        hit_slot <= cur;
        hit_rec  <= rd_data;
      end else if (rd_data.key == 32'd0 && !free_found) begin
        free_slot <= cur;
      end
    end
    if (done) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire
